@@ rtl/rfa_pkg.sv @@
`default_nettype none
package rfa_pkg;

  localparam int WIDTH = 32;
  localparam int OP_W  = 32;
  localparam int PROD_W = 2 * OP_W;

  localparam logic [PROD_W-1:0] WMASK =
    (WIDTH >= PROD_W) ? {PROD_W{1'b1}} : ((PROD_W'(1) << WIDTH) - PROD_W'(1));

  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  localparam int IN_W  = 136;
  localparam int OUT_W = 72;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [PROD_W-1:0] over_width(input logic [PROD_W-1:0] v);
    return v & ~WMASK;
  endfunction

endpackage
`default_nettype wire

@@ rtl/rfa_gcd.sv @@
`default_nettype none
module rfa_gcd
  import rfa_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [OP_W-1:0] x_in,
  input  wire logic [OP_W-1:0] y_in,
  output logic [OP_W-1:0]      g,
  output unit_stat_t           stat
);

  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_TWOS  = 3'd1;
  localparam logic [2:0] P_XODD  = 3'd2;
  localparam logic [2:0] P_MAIN  = 3'd3;
  localparam logic [2:0] P_SCALE = 3'd4;

  logic [2:0]            phase;
  logic [OP_W-1:0]       x, y;
  logic [$clog2(OP_W):0] k;
  logic                  done;

  // binary gcd: strip common twos, then subtract and shift, then scale back
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            x     <= x_in;
            y     <= y_in;
            k     <= '0;
            phase <= P_TWOS;
          end
        end
        P_TWOS: begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else begin
            phase <= P_XODD;
          end
        end
        P_XODD: begin
          if (!x[0]) x <= x >> 1;
          else phase <= P_MAIN;
        end
        P_MAIN: begin
          if (y == '0) phase <= P_SCALE;
          else if (!y[0]) y <= y >> 1;
          else if (x > y) begin
            x <= y;
            y <= x - y;
          end else begin
            y <= y - x;
          end
        end
        P_SCALE: begin
          if (k != '0) begin
            x <= x << 1;
            k <= k - 1'b1;
          end else begin
            done  <= 1'b1;
            phase <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign g         = x;
  assign stat.busy = (phase != P_IDLE);
  assign stat.done = done;

endmodule
`default_nettype wire

@@ rtl/rfa_div.sv @@
`default_nettype none
module rfa_div
  import rfa_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [OP_W-1:0] dividend,
  input  wire logic [OP_W-1:0] divisor,
  output logic [OP_W-1:0]      quotient,
  output unit_stat_t           stat
);

  logic                    busy, done;
  logic [$clog2(OP_W)-1:0] cnt;
  logic [OP_W:0]           rem;
  logic [OP_W-1:0]         q, dv;
  logic [OP_W:0]           trial;

  assign trial = {rem[OP_W-1:0], q[OP_W-1]};

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        q    <= dividend;
        dv   <= divisor;
        cnt  <= '1;
      end else if (busy) begin
        if (trial >= {1'b0, dv}) begin
          rem <= trial - {1'b0, dv};
          q   <= {q[OP_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[OP_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

@@ rtl/rational_fraction_adder.sv @@
// Rational fraction adder: adds two sign-magnitude fractions, unreduced.
// Input stream s_*: one word per operation pair. Output stream m_*: one word
// per input word, in order. Signs are 2-bit codes: 0 zero, 1 positive,
// 2 or 3 negative (output uses 3).
// Trivial cases (a zero operand or a zero denominator) skip straight to output.
// General case: binary gcd of the denominators on a subtract/shift unit,
// two restoring divisions on one shared divider, three products on one
// 32x32 multiplier, an add/compare step, then the output load.
// s_tready is high only while the sequencer is idle; one item at a time.
// The result sits in the output register until taken, and the next item is
// accepted meanwhile; it finishes its work and waits if the register is
// still full. When the receiver stalls, m_tdata and m_tvalid hold.
// Synchronous reset clears the sequencer and the output valid; no clearing
// pass or warm-up follows reset.
`default_nettype none
module rational_fraction_adder
  import rfa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // a_sign[1:0], a_num[33:2], a_den[65:34], b_sign[67:66], b_num[99:68],
  // b_den[131:100], zero pad
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // sum_sign[1:0], sum_num[33:2], sum_den[65:34], overflow[66],
  // bad_denominator[67], zero pad
  output logic [OUT_W-1:0]      m_tdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GCD   = 4'd1;
  localparam logic [3:0] S_DIVA  = 4'd2;
  localparam logic [3:0] S_DIVB  = 4'd3;
  localparam logic [3:0] S_MULL  = 4'd4;
  localparam logic [3:0] S_MULA  = 4'd5;
  localparam logic [3:0] S_MULB  = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_WAITA = 4'd9;
  localparam logic [3:0] S_WAITB = 4'd10;

  logic [3:0]        state;
  logic [1:0]        a_sign, b_sign;
  logic [OP_W-1:0]   a_num, a_den, b_num, b_den;
  logic              a_zero, b_zero, a_neg, b_neg;
  logic [OP_W-1:0]   qa, qb;
  logic [PROD_W-1:0] lcm, sa, sb, prod;
  logic [OP_W-1:0]   mul_x, mul_y;
  logic              neg_a, neg_b;
  logic [1:0]        r_sign;
  logic [OP_W-1:0]   r_num, r_den;
  logic              r_ovf, r_bad;
  logic [PROD_W:0]   add_sum;
  logic [PROD_W-1:0] pos, neg, diff;
  logic              base_ovf;
  logic              pass_neg;
  logic [OP_W-1:0]   pass_num, pass_den;
  logic              go_gcd, out_free;

  logic              gcd_start, div_start;
  logic [OP_W-1:0]   g, div_q, div_n;
  unit_stat_t        gcd_stat, div_stat;

  assign a_sign = s_tdata[1:0];
  assign a_num  = s_tdata[33:2];
  assign a_den  = s_tdata[65:34];
  assign b_sign = s_tdata[67:66];
  assign b_num  = s_tdata[99:68];
  assign b_den  = s_tdata[131:100];
  assign a_zero = (a_sign == SIGN_ZERO);
  assign b_zero = (b_sign == SIGN_ZERO);
  assign a_neg  = a_sign[1];
  assign b_neg  = b_sign[1];

  // the nonzero operand when exactly one is zero
  assign pass_neg = a_zero ? b_neg : a_neg;
  assign pass_num = a_zero ? b_num : a_num;
  assign pass_den = a_zero ? b_den : a_den;
  assign go_gcd   = !a_zero && !b_zero && (a_den != '0) && (b_den != '0);
  assign out_free = !m_tvalid || m_tready;

  logic [OP_W-1:0] an, ad, bn, bd;

  rfa_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .x_in  (ad),
    .y_in  (bd),
    .g     (g),
    .stat  (gcd_stat)
  );

  assign div_n = (state == S_DIVA) ? bd : ad;

  rfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (g),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // shared multiplier operands
  always_comb begin
    case (state)
      S_MULA:  begin mul_x = an; mul_y = qa; end
      S_MULB:  begin mul_x = bn; mul_y = qb; end
      default: begin mul_x = qb; mul_y = bd; end
    endcase
  end
  assign prod = PROD_W'(mul_x) * PROD_W'(mul_y);

  assign add_sum  = {1'b0, sa} + {1'b0, sb};
  assign pos      = neg_a ? sb : sa;
  assign neg      = neg_a ? sa : sb;
  assign diff     = (pos > neg) ? (pos - neg) : (neg - pos);
  assign base_ovf = (over_width(lcm) != '0) || (over_width(sa) != '0) ||
                    (over_width(sb) != '0);

  assign s_tready = (state == S_IDLE);

  // unit start pulses and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      gcd_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      gcd_start <= (state == S_IDLE) && s_tvalid && go_gcd;
      div_start <= ((state == S_GCD) && gcd_stat.done) || (state == S_WAITA);
      if (state == S_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            an    <= a_num;
            ad    <= a_den;
            bn    <= b_num;
            bd    <= b_den;
            neg_a <= a_neg;
            neg_b <= b_neg;
            if (go_gcd) begin
              r_bad <= 1'b0;
              state <= S_GCD;
            end else if ((a_zero && b_zero) ||
                         (!a_zero && !b_zero) || (pass_den == '0)) begin
              // both zero, or a zero denominator: 0/1
              r_sign <= SIGN_ZERO;
              r_num  <= '0;
              r_den  <= OP_W'(1);
              r_ovf  <= 1'b0;
              r_bad  <= !(a_zero && b_zero);
              state  <= S_FIN;
            end else begin
              r_sign <= pass_neg ? SIGN_NEG : SIGN_POS;
              r_num  <= pass_num;
              r_den  <= pass_den;
              r_ovf  <= (over_width(PROD_W'(pass_num)) != '0) ||
                        (over_width(PROD_W'(pass_den)) != '0);
              r_bad  <= 1'b0;
              state  <= S_FIN;
            end
          end
        end
        S_GCD: begin
          if (gcd_stat.done) state <= S_DIVA;
        end
        S_DIVA: begin
          if (div_stat.done) begin
            qa    <= div_q;
            state <= S_WAITA;
          end
        end
        S_WAITA: state <= S_DIVB;
        S_DIVB: begin
          if (div_stat.done) begin
            qb    <= div_q;
            state <= S_WAITB;
          end
        end
        S_WAITB: state <= S_MULL;
        S_MULL: begin
          lcm   <= prod;
          state <= S_MULA;
        end
        S_MULA: begin
          sa    <= prod;
          state <= S_MULB;
        end
        S_MULB: begin
          sb    <= prod;
          state <= S_ADD;
        end
        S_ADD: begin
          if (neg_a == neg_b) begin
            r_sign <= neg_a ? SIGN_NEG : SIGN_POS;
            r_num  <= add_sum[OP_W-1:0];
            r_den  <= lcm[OP_W-1:0];
            r_ovf  <= base_ovf || add_sum[PROD_W] ||
                      (over_width(add_sum[PROD_W-1:0]) != '0);
          end else if (pos == neg) begin
            r_sign <= SIGN_ZERO;
            r_num  <= '0;
            r_den  <= OP_W'(1);
            r_ovf  <= base_ovf;
          end else begin
            r_sign <= (pos > neg) ? SIGN_POS : SIGN_NEG;
            r_num  <= diff[OP_W-1:0];
            r_den  <= lcm[OP_W-1:0];
            r_ovf  <= base_ovf || (over_width(diff) != '0);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          // load the output register once it is free
          if (out_free) begin
            m_tdata <= {4'b0, r_bad, r_ovf, r_den, r_num, r_sign};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // unit busy flags are informational
  logic unused_busy;
  assign unused_busy = gcd_stat.busy ^ div_stat.busy;

endmodule
`default_nettype wire

@@ rtl/rfa_checker.sv @@
`default_nettype none
module rfa_checker
  import rfa_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic [IN_W-1:0]  s_tdata,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  logic in_unused;
  assign in_unused = ^s_tdata;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a word while busy");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == SIGN_ZERO |->
      m_tdata[33:2] == '0 && m_tdata[65:34] == OP_W'(1))
    else $error("zero sum is not 0/1");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[67] |-> m_tdata[1:0] == SIGN_ZERO && !m_tdata[66])
    else $error("bad denominator with nonzero result");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'b10)
    else $error("illegal sign code");

endmodule

bind rational_fraction_adder rfa_checker u_rfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
